### sv/rwdt_pkg.sv
package rwdt_pkg;

   // defaults for the top level parameters
   localparam int unsigned MODULE_SLOTS_DEF = 64;
   localparam int unsigned COUNT_WIDTH_DEF  = 32;

   // terminator patterns, matched on either 32-bit half
   localparam logic [31:0] TERM_ONES    = 32'hFFFF_FFFF;
   localparam logic [31:0] TERM_PATTERN = 32'h5E5E_5E5E;

   // word type in the top two bits of the upper half
   localparam logic [1:0] WTYPE_WRONG = 2'd0;
   localparam logic [1:0] WTYPE_TRACE = 2'd1;
   localparam logic [1:0] WTYPE_INFO  = 2'd2;
   localparam logic [1:0] WTYPE_ASIC  = 2'd3;

   typedef enum logic [2:0] {
      KIND_HIT        = 3'd0,
      KIND_BAD_ID     = 3'd1,
      KIND_TRIGGER    = 3'd2,
      KIND_TERMINATOR = 3'd3,
      KIND_WRONG_TYPE = 3'd4,
      KIND_UNHANDLED  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      CSR_SWAP_MODE     = 3'd0,
      CSR_HSB_CODE      = 3'd1,
      CSR_SYNC_CODE     = 3'd2,
      CSR_TRIGGER_CODE  = 3'd3,
      CSR_MODULE_LIMIT  = 3'd4,
      CSR_ASIC_LIMIT    = 3'd5,
      CSR_CHANNEL_LIMIT = 3'd6
   } csr_index_type;

   localparam logic [1:0] SWAP_MODE_RESET     = 2'd0;
   localparam logic [3:0] HSB_CODE_RESET      = 4'd5;
   localparam logic [3:0] SYNC_CODE_RESET     = 4'd4;
   localparam logic [3:0] TRIGGER_CODE_RESET  = 4'd14;
   localparam logic [6:0] MODULE_LIMIT_RESET  = 7'd3;
   localparam logic [4:0] ASIC_LIMIT_RESET    = 5'd4;
   localparam logic [7:0] CHANNEL_LIMIT_RESET = 8'd128;

endpackage

### sv/readout_word_decoder_timestamp_core.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_data_word
// rsp       out        rsp_valid / rsp_stall  rsp_record_kind .. rsp_event_count
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// one request per cycle while rsp_stall is low; a result passes the request register,
// then the result register; the counter memories are read as a
// request is taken, with a bypass from the write of the request ahead of it
// reset is synchronous: config to defaults, timestamp state and counter valid bits clear
// req_stall rises only when the request register is full and its result cannot move
module readout_word_decoder_timestamp_core #(
   parameter int unsigned MODULE_SLOTS = rwdt_pkg::MODULE_SLOTS_DEF,
   parameter int unsigned COUNT_WIDTH  = rwdt_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_record_kind,
   output logic [63:0] rsp_time_value,
   output logic [11:0] rsp_adc_value,
   output logic        rsp_hit_flag,
   output logic [5:0]  rsp_module_id,
   output logic [3:0]  rsp_asic_id,
   output logic [6:0]  rsp_channel_id,
   output logic [3:0]  rsp_code_out,
   output logic [31:0] rsp_event_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import rwdt_pkg::*;

   localparam int unsigned SlotAw  = (MODULE_SLOTS > 1) ? $clog2(MODULE_SLOTS) : 1;
   localparam int unsigned CntExtW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam logic [6:0]  SlotLimit = 7'(MODULE_SLOTS);

   // configuration
   logic [1:0] swap_mode_ff;
   logic [3:0] hsb_code_ff, sync_code_ff, trig_code_ff;
   logic [6:0] module_limit_ff;
   logic [4:0] asic_limit_ff;
   logic [7:0] channel_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_mode_ff     <= SWAP_MODE_RESET;
         hsb_code_ff      <= HSB_CODE_RESET;
         sync_code_ff     <= SYNC_CODE_RESET;
         trig_code_ff     <= TRIGGER_CODE_RESET;
         module_limit_ff  <= MODULE_LIMIT_RESET;
         asic_limit_ff    <= ASIC_LIMIT_RESET;
         channel_limit_ff <= CHANNEL_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SWAP_MODE:     swap_mode_ff     <= csr_data[1:0];
            CSR_HSB_CODE:      hsb_code_ff      <= csr_data[3:0];
            CSR_SYNC_CODE:     sync_code_ff     <= csr_data[3:0];
            CSR_TRIGGER_CODE:  trig_code_ff     <= csr_data[3:0];
            CSR_MODULE_LIMIT:  module_limit_ff  <= csr_data[6:0];
            CSR_ASIC_LIMIT:    asic_limit_ff    <= csr_data[4:0];
            CSR_CHANNEL_LIMIT: channel_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // swap on the way in
   logic [63:0] rev_word, swap_word;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         rev_word[8*k +: 8] = req_data_word[8*(7-k) +: 8];
      end
      swap_word = swap_mode_ff[0] ? rev_word : req_data_word;
      if (swap_mode_ff[1]) begin
         swap_word = {swap_word[31:0], swap_word[63:32]};
      end
   end

   // request register
   logic        s1_valid_ff;
   logic [63:0] s1_word_ff;
   logic        s1_adv;
   logic        req_accept;

   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff <= swap_word;
      end
   end

   // counter memories, read as a request is taken
   logic [5:0]        rd_hit_mod, rd_trig_mod;
   logic [SlotAw-1:0] rd_hit_addr, rd_trig_addr;

   assign rd_hit_mod   = swap_word[60:55];
   assign rd_trig_mod  = swap_word[61:56];
   assign rd_hit_addr  = ({1'b0, rd_hit_mod} < SlotLimit) ? rd_hit_mod[SlotAw-1:0] : '0;
   assign rd_trig_addr = ({1'b0, rd_trig_mod} < SlotLimit) ? rd_trig_mod[SlotAw-1:0] : '0;

   logic [COUNT_WIDTH-1:0] hit_mem  [MODULE_SLOTS];
   logic [COUNT_WIDTH-1:0] trig_mem [MODULE_SLOTS];
   logic [MODULE_SLOTS-1:0] hit_vld_ff, trig_vld_ff;

   logic [COUNT_WIDTH-1:0] hit_rd_ff, trig_rd_ff;
   logic                   hit_rvld_ff, trig_rvld_ff;
   logic                   hit_byp_ff, trig_byp_ff;
   logic [COUNT_WIDTH-1:0] hit_byp_data_ff, trig_byp_data_ff;

   logic                   hit_wr, trig_wr;
   logic [SlotAw-1:0]      hit_waddr, trig_waddr;
   logic [COUNT_WIDTH-1:0] hit_wdata, trig_wdata;

   always_ff @(posedge clock) begin
      if (hit_wr) begin
         hit_mem[hit_waddr] <= hit_wdata;
      end
      if (trig_wr) begin
         trig_mem[trig_waddr] <= trig_wdata;
      end
      if (req_accept) begin
         hit_rd_ff        <= hit_mem[rd_hit_addr];
         trig_rd_ff       <= trig_mem[rd_trig_addr];
         hit_rvld_ff      <= hit_vld_ff[rd_hit_addr];
         trig_rvld_ff     <= trig_vld_ff[rd_trig_addr];
         // the request ahead writes in this same cycle
         hit_byp_ff       <= hit_wr && (hit_waddr == rd_hit_addr);
         trig_byp_ff      <= trig_wr && (trig_waddr == rd_trig_addr);
         hit_byp_data_ff  <= hit_wdata;
         trig_byp_data_ff <= trig_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_vld_ff  <= '0;
         trig_vld_ff <= '0;
      end else begin
         if (hit_wr) begin
            hit_vld_ff[hit_waddr] <= 1'b1;
         end
         if (trig_wr) begin
            trig_vld_ff[trig_waddr] <= 1'b1;
         end
      end
   end

   // timestamp state
   logic [19:0] time_high_ff, time_middle_ff;
   logic        high_ready_ff;
   logic [19:0] time_high_in, time_middle_in;
   logic        high_ready_in;

   // decode of the word in the request register
   logic [31:0] w0, w1;
   logic [1:0]  wtype;
   logic [27:0] lsb;
   logic        is_term;
   logic [5:0]  a_mod, i_mod;
   logic [3:0]  a_asic, i_code;
   logic [6:0]  a_ch;
   logic [19:0] i_field;
   logic        a_bad, a_slot_ok, i_slot_ok;
   logic        hsb_hit, sync_hit, trig_hit;
   logic [COUNT_WIDTH-1:0] hit_cnt, trig_cnt;

   logic        emit;
   kind_type    kind_in;
   logic [63:0] time_in;
   logic [11:0] adc_in;
   logic        hitf_in;
   logic [5:0]  mod_in;
   logic [3:0]  asic_in, code_in;
   logic [6:0]  ch_in;
   logic [COUNT_WIDTH-1:0] count_in;

   assign w0      = s1_word_ff[63:32];
   assign w1      = s1_word_ff[31:0];
   assign wtype   = w0[31:30];
   assign lsb     = w1[27:0];
   assign is_term = (w0 == TERM_ONES) || (w0 == TERM_PATTERN) ||
                    (w1 == TERM_ONES) || (w1 == TERM_PATTERN);

   assign a_mod     = w0[28:23];
   assign a_asic    = w0[22:19];
   assign a_ch      = w0[18:12];
   assign a_slot_ok = {1'b0, a_mod} < SlotLimit;
   assign a_bad     = ({1'b0, a_mod} >= module_limit_ff) ||
                      ({1'b0, a_asic} >= asic_limit_ff) ||
                      ({1'b0, a_ch} >= channel_limit_ff) || !a_slot_ok;

   assign i_field   = w0[19:0];
   assign i_code    = w0[23:20];
   assign i_mod     = w0[29:24];
   assign i_slot_ok = {1'b0, i_mod} < SlotLimit;
   assign hsb_hit   = i_code == hsb_code_ff;
   assign sync_hit  = i_code == sync_code_ff;
   assign trig_hit  = i_code == trig_code_ff;

   assign hit_cnt  = hit_byp_ff ? hit_byp_data_ff : (hit_rvld_ff ? hit_rd_ff : '0);
   assign trig_cnt = trig_byp_ff ? trig_byp_data_ff : (trig_rvld_ff ? trig_rd_ff : '0);

   assign hit_waddr  = a_mod[SlotAw-1:0];
   assign trig_waddr = i_mod[SlotAw-1:0];
   assign hit_wdata  = hit_cnt + COUNT_WIDTH'(1);
   assign trig_wdata = trig_cnt + COUNT_WIDTH'(1);

   always_comb begin
      emit           = 1'b1;
      kind_in        = KIND_UNHANDLED;
      time_in        = '0;
      adc_in         = '0;
      hitf_in        = 1'b0;
      mod_in         = '0;
      asic_in        = '0;
      ch_in          = '0;
      code_in        = '0;
      count_in       = '0;
      time_high_in   = time_high_ff;
      time_middle_in = time_middle_ff;
      high_ready_in  = high_ready_ff;
      hit_wr         = 1'b0;
      trig_wr        = 1'b0;

      if (is_term) begin
         kind_in = KIND_TERMINATOR;
      end else if (wtype == WTYPE_ASIC && w1[28]) begin
         high_ready_in = 1'b0;
         time_in = {time_high_ff[15:0], time_middle_ff, lsb};
         adc_in  = w0[11:0];
         hitf_in = w0[29];
         mod_in  = a_mod;
         asic_in = a_asic;
         ch_in   = a_ch;
         if (a_bad) begin
            kind_in = KIND_BAD_ID;
         end else begin
            kind_in  = KIND_HIT;
            count_in = hit_cnt;
            hit_wr   = s1_adv;
         end
      end else if (wtype == WTYPE_INFO) begin
         emit = 1'b0;
         if (hsb_hit) begin
            time_high_in  = i_field;
            high_ready_in = 1'b1;
         end
         if (sync_hit || trig_hit) begin
            time_middle_in = i_field;
            high_ready_in  = 1'b0;
            // high part counts only when loaded since the last sync, trigger or hit
            time_in = {(hsb_hit || high_ready_ff) ? time_high_in[15:0] : 16'd0,
                       i_field, lsb};
         end
         if (trig_hit) begin
            emit    = 1'b1;
            kind_in = KIND_TRIGGER;
            mod_in  = i_mod;
            code_in = i_code;
            if (i_slot_ok) begin
               count_in = trig_cnt;
               trig_wr  = s1_adv;
            end
         end
      end else if (wtype == WTYPE_WRONG) begin
         kind_in = KIND_WRONG_TYPE;
      end else begin
         kind_in = KIND_UNHANDLED;
      end
   end

   // result register
   logic        out_valid_ff;
   kind_type    out_kind_ff;
   logic [63:0] out_time_ff;
   logic [11:0] out_adc_ff;
   logic        out_hit_ff;
   logic [5:0]  out_mod_ff;
   logic [3:0]  out_asic_ff, out_code_ff;
   logic [6:0]  out_ch_ff;
   logic [31:0] out_count_ff;
   logic [CntExtW-1:0] count_ext;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || !rsp_stall || !emit);
   assign count_ext = CntExtW'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         time_high_ff   <= '0;
         time_middle_ff <= '0;
         high_ready_ff  <= 1'b0;
      end else begin
         if (s1_adv && emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            time_high_ff   <= time_high_in;
            time_middle_ff <= time_middle_in;
            high_ready_ff  <= high_ready_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && emit) begin
         out_kind_ff  <= kind_in;
         out_time_ff  <= time_in;
         out_adc_ff   <= adc_in;
         out_hit_ff   <= hitf_in;
         out_mod_ff   <= mod_in;
         out_asic_ff  <= asic_in;
         out_ch_ff    <= ch_in;
         out_code_ff  <= code_in;
         out_count_ff <= count_ext[31:0];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_record_kind = out_kind_ff;
   assign rsp_time_value  = out_time_ff;
   assign rsp_adc_value   = out_adc_ff;
   assign rsp_hit_flag    = out_hit_ff;
   assign rsp_module_id   = out_mod_ff;
   assign rsp_asic_id     = out_asic_ff;
   assign rsp_channel_id  = out_ch_ff;
   assign rsp_code_out    = out_code_ff;
   assign rsp_event_count = out_count_ff;

`ifndef ASSERT_OFF
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with an empty request register");

   a_term_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == KIND_TERMINATOR |->
         rsp_time_value == '0 && rsp_event_count == '0 && rsp_module_id == '0)
      else $error("terminator record carries data");

   a_bad_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == KIND_BAD_ID |-> rsp_event_count == '0)
      else $error("bad id record carries a count");

   a_trigger_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == KIND_TRIGGER |->
         rsp_adc_value == '0 && !rsp_hit_flag && rsp_channel_id == '0)
      else $error("trigger record carries hit fields");

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> hit_vld_ff == '0 && trig_vld_ff == '0)
      else $error("counter valid bits not cleared by reset");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(hit_wr && trig_wr))
      else $error("one word updated both counter stores");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rwdt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_SETTLE = 6;
   localparam int HOLD_CYCLES = 120;

   typedef struct {
      kind_type    kind;
      logic [63:0] time_value;
      logic [11:0] adc_value;
      logic        hit_flag;
      logic [5:0]  module_id;
      logic [3:0]  asic_id;
      logic [6:0]  channel_id;
      logic [3:0]  code_out;
      logic [31:0] event_count;
   } decoded_record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_data_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_record_kind;
   logic [63:0] rsp_time_value;
   logic [11:0] rsp_adc_value;
   logic        rsp_hit_flag;
   logic [5:0]  rsp_module_id;
   logic [3:0]  rsp_asic_id;
   logic [6:0]  rsp_channel_id;
   logic [3:0]  rsp_code_out;
   logic [31:0] rsp_event_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_SWAP_MODE;
   logic [7:0]  csr_data = '0;

   // decoder settings as last written
   logic [1:0]  cfg_swap;
   logic [3:0]  cfg_hsb_code;
   logic [3:0]  cfg_sync_code;
   logic [3:0]  cfg_trigger_code;
   logic [6:0]  cfg_module_limit;
   logic [4:0]  cfg_asic_limit;
   logic [7:0]  cfg_channel_limit;

   // timestamp parts and per-module counters
   logic [19:0] stamp_high;
   logic [19:0] stamp_middle;
   logic        stamp_high_valid;
   logic [31:0] hit_count [64];
   logic [31:0] trigger_count [64];

   decoded_record_type pending_records[$];
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   readout_word_decoder_timestamp_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_record_kind (rsp_record_kind),
      .rsp_time_value  (rsp_time_value),
      .rsp_adc_value   (rsp_adc_value),
      .rsp_hit_flag    (rsp_hit_flag),
      .rsp_module_id   (rsp_module_id),
      .rsp_asic_id     (rsp_asic_id),
      .rsp_channel_id  (rsp_channel_id),
      .rsp_code_out    (rsp_code_out),
      .rsp_event_count (rsp_event_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] reverse_bytes(input logic [63:0] w);
      logic [63:0] r;
      for (int k = 0; k < 8; k++) r[8*k +: 8] = w[8*(7-k) +: 8];
      return r;
   endfunction

   task automatic clear_decoder_state();
      cfg_swap          = SWAP_MODE_RESET;
      cfg_hsb_code      = HSB_CODE_RESET;
      cfg_sync_code     = SYNC_CODE_RESET;
      cfg_trigger_code  = TRIGGER_CODE_RESET;
      cfg_module_limit  = MODULE_LIMIT_RESET;
      cfg_asic_limit    = ASIC_LIMIT_RESET;
      cfg_channel_limit = CHANNEL_LIMIT_RESET;
      stamp_high        = '0;
      stamp_middle      = '0;
      stamp_high_valid  = 1'b0;
      for (int k = 0; k < 64; k++) begin
         hit_count[k]     = '0;
         trigger_count[k] = '0;
      end
   endtask

   // decode one word, update the timestamp and counter state, return 1 if a record results
   function automatic bit decode_word(input logic [63:0] raw, output decoded_record_type rec);
      logic [63:0] w;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [27:0] lsb;
      logic [5:0]  mod;
      logic [3:0]  code;
      logic [63:0] stamp;
      bit          timed;
      w = raw;
      if (cfg_swap[0]) w = reverse_bytes(w);
      if (cfg_swap[1]) w = {w[31:0], w[63:32]};
      w0 = w[63:32];
      w1 = w[31:0];
      lsb = w1[27:0];
      rec.kind        = KIND_TERMINATOR;
      rec.time_value  = '0;
      rec.adc_value   = '0;
      rec.hit_flag    = 1'b0;
      rec.module_id   = '0;
      rec.asic_id     = '0;
      rec.channel_id  = '0;
      rec.code_out    = '0;
      rec.event_count = '0;
      if (w0 == TERM_ONES || w0 == TERM_PATTERN || w1 == TERM_ONES || w1 == TERM_PATTERN)
         return 1'b1;
      case (w0[31:30])
         WTYPE_ASIC: begin
            if (!w1[28]) begin
               rec.kind = KIND_UNHANDLED;
               return 1'b1;
            end
            mod = w0[28:23];
            rec.adc_value  = w0[11:0];
            rec.hit_flag   = w0[29];
            rec.module_id  = mod;
            rec.asic_id    = w0[22:19];
            rec.channel_id = w0[18:12];
            rec.time_value = {stamp_high[15:0], stamp_middle, lsb};
            stamp_high_valid = 1'b0;
            if (mod >= cfg_module_limit || w0[22:19] >= cfg_asic_limit ||
                w0[18:12] >= cfg_channel_limit) begin
               rec.kind = KIND_BAD_ID;
            end else begin
               rec.kind = KIND_HIT;
               rec.event_count = hit_count[mod];
               hit_count[mod] = hit_count[mod] + 1;
            end
            return 1'b1;
         end
         WTYPE_INFO: begin
            code = w0[23:20];
            mod = w0[29:24];
            timed = 1'b0;
            // codes may coincide, so every match applies in turn
            if (code == cfg_hsb_code) begin
               stamp_high = w0[19:0];
               stamp_high_valid = 1'b1;
            end
            if (code == cfg_sync_code) begin
               stamp_middle = w0[19:0];
               timed = 1'b1;
            end
            if (code == cfg_trigger_code) begin
               stamp_middle = w0[19:0];
               timed = 1'b1;
            end
            if (!timed) return 1'b0;
            stamp = stamp_high_valid ? {stamp_high[15:0], stamp_middle, lsb}
                                     : {16'h0, stamp_middle, lsb};
            stamp_high_valid = 1'b0;
            if (code != cfg_trigger_code) return 1'b0;
            rec.kind = KIND_TRIGGER;
            rec.time_value = stamp;
            rec.module_id = mod;
            rec.code_out = code;
            rec.event_count = trigger_count[mod];
            trigger_count[mod] = trigger_count[mod] + 1;
            return 1'b1;
         end
         WTYPE_WRONG: begin
            rec.kind = KIND_WRONG_TYPE;
            return 1'b1;
         end
         default: begin
            rec.kind = KIND_UNHANDLED;
            return 1'b1;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // results are checked before the request of the same edge is decoded
   always @(posedge clock) begin
      decoded_record_type head;
      decoded_record_type rec;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_records.size() == 0) begin
               $error("record_kind: expected no result, got 0x%0h", rsp_record_kind);
               mismatches++;
            end else begin
               head = pending_records.pop_front();
               check_field("record_kind", 64'(head.kind), 64'(rsp_record_kind));
               check_field("time_value", head.time_value, rsp_time_value);
               check_field("adc_value", 64'(head.adc_value), 64'(rsp_adc_value));
               check_field("hit_flag", 64'(head.hit_flag), 64'(rsp_hit_flag));
               check_field("module_id", 64'(head.module_id), 64'(rsp_module_id));
               check_field("asic_id", 64'(head.asic_id), 64'(rsp_asic_id));
               check_field("channel_id", 64'(head.channel_id), 64'(rsp_channel_id));
               check_field("code_out", 64'(head.code_out), 64'(rsp_code_out));
               check_field("event_count", 64'(head.event_count), 64'(rsp_event_count));
            end
         end
         if (req_valid && !req_stall && decode_word(req_data_word, rec))
            pending_records.push_back(rec);
      end
   end

   // result side: random stalls plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(99) < 12);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_word(input logic [63:0] raw);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_word <= raw;
      do @(posedge clock); while (req_stall);
      // a gap after about one word in twenty
      if (req_gaps_on && $urandom_range(99) < 5) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data_word <= {32'($urandom), 32'($urandom)};
         repeat ($urandom_range(3)) @(negedge clock);
      end
   endtask

   // words are built as the decoder sees them, then put in the wire order
   task automatic send_logical(input logic [63:0] w);
      logic [63:0] raw;
      raw = w;
      if (cfg_swap[1]) raw = {raw[31:0], raw[63:32]};
      if (cfg_swap[0]) raw = reverse_bytes(raw);
      send_word(raw);
   endtask

   function automatic logic [63:0] asic_word(input logic hit, input logic [5:0] mod,
                                             input logic [3:0] asic, input logic [6:0] ch,
                                             input logic [11:0] adc, input logic [27:0] lsb);
      return {WTYPE_ASIC, hit, mod, asic, ch, adc, 3'($urandom), 1'b1, lsb};
   endfunction

   function automatic logic [63:0] info_word(input logic [3:0] code, input logic [5:0] mod,
                                             input logic [19:0] field,
                                             input logic [27:0] lsb);
      return {WTYPE_INFO, mod, code, field, 4'($urandom), lsb};
   endfunction

   function automatic int pick_below(input int limit, input int top);
      if (limit == 0 || $urandom_range(9) == 0) return $urandom_range(top);
      return $urandom_range((limit > top + 1 ? top + 1 : limit) - 1);
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SWAP_MODE:     cfg_swap = value[1:0];
         CSR_HSB_CODE:      cfg_hsb_code = value[3:0];
         CSR_SYNC_CODE:     cfg_sync_code = value[3:0];
         CSR_TRIGGER_CODE:  cfg_trigger_code = value[3:0];
         CSR_MODULE_LIMIT:  cfg_module_limit = value[6:0];
         CSR_ASIC_LIMIT:    cfg_asic_limit = value[4:0];
         CSR_CHANNEL_LIMIT: cfg_channel_limit = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_item();
      int          pick;
      logic [63:0] w;
      pick = $urandom_range(99);
      w = {32'($urandom), 32'($urandom)};
      if (pick < 40) begin
         w = asic_word(1'($urandom), 6'(pick_below(int'(cfg_module_limit), 63)),
                       4'(pick_below(int'(cfg_asic_limit), 15)),
                       7'(pick_below(int'(cfg_channel_limit), 127)), 12'($urandom),
                       28'($urandom));
      end else if (pick < 48) begin
         w = asic_word(1'($urandom), 6'($urandom), 4'($urandom), 7'($urandom),
                       12'($urandom), 28'($urandom));
      end else if (pick < 58) begin
         w = info_word(cfg_hsb_code, 6'($urandom), 20'($urandom), 28'($urandom));
      end else if (pick < 68) begin
         w = info_word(cfg_sync_code, 6'($urandom), 20'($urandom), 28'($urandom));
      end else if (pick < 80) begin
         w = info_word(cfg_trigger_code, 6'(pick_below(int'(cfg_module_limit), 63)),
                       20'($urandom), 28'($urandom));
      end else if (pick < 84) begin
         w = info_word(4'($urandom), 6'($urandom), 20'($urandom), 28'($urandom));
      end else if (pick < 88) begin
         case ($urandom_range(3))
            0: w[63:32] = TERM_ONES;
            1: w[63:32] = TERM_PATTERN;
            2: w[31:0] = TERM_ONES;
            default: w[31:0] = TERM_PATTERN;
         endcase
      end else if (pick < 94) begin
         case ($urandom_range(2))
            0: w[63:62] = WTYPE_WRONG;
            1: w[63:62] = WTYPE_TRACE;
            default: begin
               // digitizer word: asic type with the marker bit clear
               w[63:62] = WTYPE_ASIC;
               w[28] = 1'b0;
            end
         endcase
      end
      send_logical(w);
   endtask

   task automatic test_directed_words();
      send_logical(64'h0);
      send_logical({64{1'b1}});
      send_logical({TERM_PATTERN, 32'h0});
      send_logical({32'h8000_0000, TERM_ONES});
      send_logical({32'h4000_0000, TERM_PATTERN});
      send_logical({WTYPE_TRACE, 30'h3FFF_FFFF, 32'h0});
      send_logical({WTYPE_ASIC, 30'h0, 32'hEFFF_FFFF});
      // hit before any timestamp has arrived
      send_logical(asic_word(1'b0, 6'd0, 4'd0, 7'd0, 12'h000, 28'h0));
      send_logical(info_word(HSB_CODE_RESET, 6'd0, 20'hFFFFF, 28'h0));
      send_logical(info_word(SYNC_CODE_RESET, 6'd0, 20'hFFFFF, 28'hFFF_FFFF));
      send_logical(asic_word(1'b1, 6'd2, 4'd3, 7'd127, 12'hFFF, 28'hFFF_FFFE));
      // trigger with no high part pending
      send_logical(info_word(TRIGGER_CODE_RESET, 6'd63, 20'h12345, 28'h0AB_CDEF));
      send_logical(info_word(HSB_CODE_RESET, 6'd0, 20'hABCDE, 28'h0));
      send_logical(info_word(TRIGGER_CODE_RESET, 6'd0, 20'h00001, 28'h123_4567));
      send_logical(info_word(TRIGGER_CODE_RESET, 6'd0, 20'h80000, 28'h765_4321));
      send_logical(asic_word(1'b0, 6'd3, 4'd0, 7'd0, 12'h123, 28'h1));
      send_logical(asic_word(1'b1, 6'd63, 4'd15, 7'd127, 12'hFFF, 28'hFFF_FFFE));
      send_logical(asic_word(1'b0, 6'd0, 4'd4, 7'd5, 12'h456, 28'h2));
      send_logical(info_word(4'd0, 6'd5, 20'h55555, 28'h3));
      send_logical(info_word(4'd15, 6'd63, 20'hFFFFF, 28'h4));
      // a hit between the high part and a trigger drops the high part
      send_logical(info_word(HSB_CODE_RESET, 6'd1, 20'h0F0F0, 28'h5));
      send_logical(asic_word(1'b1, 6'd1, 4'd1, 7'd64, 12'h800, 28'h6));
      send_logical(info_word(TRIGGER_CODE_RESET, 6'd1, 20'h3C3C3, 28'h7));
      send_logical(asic_word(1'b0, 6'd0, 4'd2, 7'd1, 12'h001, 28'h8));
   endtask

   task automatic test_coinciding_codes();
      wait_idle();
      write_csr(CSR_HSB_CODE, 8'd15);
      write_csr(CSR_SYNC_CODE, 8'd15);
      write_csr(CSR_TRIGGER_CODE, 8'd15);
      send_logical(info_word(4'd15, 6'd1, 20'hA5A5A, 28'h123_4567));
      send_logical(asic_word(1'b1, 6'd0, 4'd0, 7'd9, 12'h5A5, 28'h9));
      send_logical(info_word(4'd15, 6'd1, 20'h5A5A5, 28'hFFF_FFFE));
      wait_idle();
      write_csr(CSR_HSB_CODE, 8'd0);
      write_csr(CSR_SYNC_CODE, 8'd9);
      write_csr(CSR_TRIGGER_CODE, 8'd0);
      send_logical(info_word(4'd0, 6'd2, 20'h11111, 28'hA));
      send_logical(info_word(4'd9, 6'd2, 20'h22222, 28'hB));
      send_logical(info_word(4'd0, 6'd2, 20'h33333, 28'hC));
      send_logical(asic_word(1'b0, 6'd2, 4'd3, 7'd3, 12'h333, 28'hD));
      wait_idle();
      write_csr(CSR_HSB_CODE, 8'd3);
      write_csr(CSR_SYNC_CODE, 8'd3);
      write_csr(CSR_TRIGGER_CODE, 8'd12);
      send_logical(info_word(4'd3, 6'd0, 20'h44444, 28'hE));
      send_logical(info_word(4'd12, 6'd0, 20'h55555, 28'hF));
      send_logical(info_word(4'd3, 6'd0, 20'h66666, 28'h10));
      send_logical(asic_word(1'b1, 6'd0, 4'd0, 7'd0, 12'h666, 28'h11));
   endtask

   task automatic test_id_limits();
      logic [7:0] limits [6][3];
      limits = '{'{8'd0, 8'd16, 8'd128}, '{8'd64, 8'd0, 8'd128}, '{8'd64, 8'd16, 8'd0},
                 '{8'd127, 8'd31, 8'd255}, '{8'd64, 8'd16, 8'd1}, '{8'd2, 8'd1, 8'd128}};
      for (int s = 0; s < 6; s++) begin
         wait_idle();
         write_csr(CSR_MODULE_LIMIT, limits[s][0]);
         write_csr(CSR_ASIC_LIMIT, limits[s][1]);
         write_csr(CSR_CHANNEL_LIMIT, limits[s][2]);
         repeat (15)
            send_logical(asic_word(1'($urandom),
                                   6'(pick_below(int'(cfg_module_limit), 63)),
                                   4'(pick_below(int'(cfg_asic_limit), 15)),
                                   7'(pick_below(int'(cfg_channel_limit), 127)),
                                   12'($urandom), 28'($urandom)));
      end
   endtask

   task automatic test_swap_modes();
      for (int m = 0; m < 4; m++) begin
         wait_idle();
         write_csr(CSR_SWAP_MODE, 8'(m));
         repeat (30) send_random_item();
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_request = 1'b1;
      repeat (40) send_random_item();
      wait_idle();
   endtask

   task automatic set_stream_config(input int phase);
      case (phase)
         0: begin
            write_csr(CSR_SWAP_MODE, 8'd0);
            write_csr(CSR_MODULE_LIMIT, 8'd1);
            write_csr(CSR_ASIC_LIMIT, 8'd1);
            write_csr(CSR_CHANNEL_LIMIT, 8'd1);
         end
         1: begin
            write_csr(CSR_SWAP_MODE, 8'd3);
            write_csr(CSR_MODULE_LIMIT, 8'd64);
            write_csr(CSR_ASIC_LIMIT, 8'd16);
            write_csr(CSR_CHANNEL_LIMIT, 8'd128);
         end
         default: begin
            write_csr(CSR_SWAP_MODE, 8'($urandom_range(3)));
            write_csr(CSR_MODULE_LIMIT, 8'($urandom_range(64, 1)));
            write_csr(CSR_ASIC_LIMIT, 8'($urandom_range(16, 1)));
            write_csr(CSR_CHANNEL_LIMIT, 8'($urandom_range(128, 1)));
         end
      endcase
      write_csr(CSR_HSB_CODE, 8'($urandom_range(15)));
      write_csr(CSR_SYNC_CODE, 8'($urandom_range(15)));
      write_csr(CSR_TRIGGER_CODE, 8'($urandom_range(15)));
   endtask

   task automatic test_random_stream();
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         set_stream_config(phase);
         // one phase runs flat out on both sides
         req_gaps_on = (phase != 2);
         rsp_gaps_on = (phase != 2);
         repeat (170) send_random_item();
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   initial begin
      clear_decoder_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_words();
      test_coinciding_codes();
      test_id_limits();
      test_swap_modes();
      test_backpressure();
      test_random_stream();
      wait_idle();
      if (mismatches == 0 && pending_records.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### readout_word_decoder_timestamp_core.f
sv/rwdt_pkg.sv
sv/readout_word_decoder_timestamp_core.sv
tb/tb_top.sv
